// File: sv/lix_pkg.sv
// Shared types and constants for the 2D line intersection pipeline.
// No dependencies; used by every module of the block and by its checker.
package lix_pkg;

  localparam int COORD_WIDTH_DEF = 32;   // default saturation width of a coordinate
  localparam int EPS_WIDTH       = 63;   // epsilon register width, Q63.0 magnitude
  localparam int QUO_BITS        = 62;   // quotient bits resolved by the cell row
  localparam int NUM_WIDTH       = 96;   // |n| * |dir| numerator width
  localparam int DEN_WIDTH       = 64;   // |cross(dir_a, dir_b)| width
  localparam int FRONT_STAGES    = 7;
  localparam int LATENCY         = FRONT_STAGES + QUO_BITS + 1;

  typedef enum logic [1:0] {
    HIT_NONE       = 2'd0,
    HIT_POINT      = 2'd1,
    HIT_COINCIDENT = 2'd2
  } hit_kind_t;

  // Payload handed from cell to cell along the divider row.
  typedef struct packed {
    logic                   valid;
    hit_kind_t              kind;
    logic [DEN_WIDTH-1:0]   den;
    logic [NUM_WIDTH-1:0]   rem_x;
    logic [NUM_WIDTH-1:0]   rem_y;
    logic [QUO_BITS-1:0]    quo_x;
    logic [QUO_BITS-1:0]    quo_y;
    logic                   neg_x;
    logic                   neg_y;
    logic                   big_x;
    logic                   big_y;
    logic signed [31:0]     base_x;
    logic signed [31:0]     base_y;
  } lix_div_t;

endpackage

// File: sv/line_intersection_2d.sv
// done rises once a transfer on start has passed the 7 front stages, the 62 cells
// and the 1 output register. Throughput: one line pair per cycle, fully pipelined;
// busy is low except in the cycle right after reset.
// Reset (rst, synchronous, high): empties the pipeline, epsilon back to 1.
// The receiver cannot stall; every result is shown for exactly one cycle.
module line_intersection_2d #(
  parameter int COORD_WIDTH = lix_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cfg_we,
  input  logic [lix_pkg::EPS_WIDTH-1:0] cfg_wdata,
  input  logic signed [31:0]            first_point_x,
  input  logic signed [31:0]            first_point_y,
  input  logic signed [31:0]            first_dir_x,
  input  logic signed [31:0]            first_dir_y,
  input  logic signed [31:0]            second_point_x,
  input  logic signed [31:0]            second_point_y,
  input  logic signed [31:0]            second_dir_x,
  input  logic signed [31:0]            second_dir_y,
  output logic                          done,
  output logic [1:0]                    hit_kind,
  output logic signed [31:0]            cross_x,
  output logic signed [31:0]            cross_y,
  output logic                          overflow
);

  // Parallel threshold, Q63.0 magnitude.
  logic [lix_pkg::EPS_WIDTH-1:0] collinear_epsilon;
  logic                          accept;

  // chain[0] is the front end's output; chain[k+1] leaves cell k.
  lix_pkg::lix_div_t chain [0:lix_pkg::QUO_BITS];

  // busy only covers the cycle after reset; the pipeline never stalls.
  always_ff @(posedge clk) begin
    busy <= rst;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      collinear_epsilon <= lix_pkg::EPS_WIDTH'(1);
    end else if (cfg_we) begin
      collinear_epsilon <= cfg_wdata;
    end
  end

  assign accept = start & ~busy;

  // Cross products, parallel check and |n|*|dir| numerators.
  lix_front u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .eps            (collinear_epsilon),
    .first_point_x  (first_point_x),
    .first_point_y  (first_point_y),
    .first_dir_x    (first_dir_x),
    .first_dir_y    (first_dir_y),
    .second_point_x (second_point_x),
    .second_point_y (second_point_y),
    .second_dir_x   (second_dir_x),
    .second_dir_y   (second_dir_y),
    .div_out        (chain[0])
  );

  // Division row, MSB first: cell k settles quotient bit QUO_BITS-1-k.
  for (genvar k = 0; k < lix_pkg::QUO_BITS; k++) begin : g_cell
    lix_cell #(
      .BIT (lix_pkg::QUO_BITS - 1 - k)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_in  (chain[k]),
      .cell_out (chain[k+1])
    );
  end

  // Sign, base add, saturation and the output register.
  lix_back #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .div_in   (chain[lix_pkg::QUO_BITS]),
    .done     (done),
    .hit_kind (hit_kind),
    .cross_x  (cross_x),
    .cross_y  (cross_y),
    .overflow (overflow)
  );

endmodule

// File: sv/lix_front.sv
// Front pipeline: cross products, parallel test and division numerators.
// Depends on lix_pkg; feeds the first cell of the divider row.
module lix_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               accept,
  input  logic [lix_pkg::EPS_WIDTH-1:0]      eps,
  input  logic signed [31:0]                 first_point_x,
  input  logic signed [31:0]                 first_point_y,
  input  logic signed [31:0]                 first_dir_x,
  input  logic signed [31:0]                 first_dir_y,
  input  logic signed [31:0]                 second_point_x,
  input  logic signed [31:0]                 second_point_y,
  input  logic signed [31:0]                 second_dir_x,
  input  logic signed [31:0]                 second_dir_y,
  output lix_pkg::lix_div_t                  div_out
);

  // stage A: inputs and point offset
  logic               a_valid;
  logic signed [31:0] a_ax, a_ay, a_ux, a_uy, a_vx, a_vy;
  logic signed [32:0] a_ex, a_ey;
  // stage B: products
  logic               b_valid;
  logic signed [31:0] b_ax, b_ay, b_ux, b_uy;
  logic signed [63:0] b_pd1, b_pd2;
  logic signed [64:0] b_pn1, b_pn2;
  // stage C: cross products
  logic               c_valid;
  logic signed [31:0] c_ax, c_ay, c_ux, c_uy;
  logic signed [64:0] c_d;
  logic signed [65:0] c_n;
  // stage D: magnitudes and classification
  logic               d_valid;
  lix_pkg::hit_kind_t d_kind;
  logic signed [31:0] d_ax, d_ay;
  logic [63:0]        d_dmag;
  logic [64:0]        d_nmag;
  logic [31:0]        d_mux, d_muy;
  logic               d_negx, d_negy;
  // stage E: partial products
  logic               e_valid;
  lix_pkg::hit_kind_t e_kind;
  logic signed [31:0] e_ax, e_ay;
  logic [63:0]        e_den;
  logic [63:0]        e_plx, e_ply;
  logic [64:0]        e_phx, e_phy;
  logic               e_negx, e_negy;
  // stage F: numerators
  logic               f_valid;
  lix_pkg::hit_kind_t f_kind;
  logic signed [31:0] f_ax, f_ay;
  logic [63:0]        f_den;
  logic [95:0]        f_numx, f_numy;
  logic               f_negx, f_negy;

  logic signed [64:0] dabs;
  logic signed [65:0] nabs;
  logic               par_d, par_n;
  logic [63:0]        dmag_c;
  logic [64:0]        nmag_c;

  always_comb begin
    dabs   = c_d[64] ? -c_d : c_d;
    nabs   = c_n[65] ? -c_n : c_n;
    dmag_c = dabs[63:0];
    nmag_c = nabs[64:0];
    par_d  = (dmag_c == 64'd0) || (dmag_c < {1'b0, eps});
    par_n  = (nmag_c == 65'd0) || (nmag_c < {2'b0, eps});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
      e_valid <= 1'b0;
      f_valid <= 1'b0;
    end else begin
      a_valid <= accept;
      b_valid <= a_valid;
      c_valid <= b_valid;
      d_valid <= c_valid;
      e_valid <= d_valid;
      f_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    // A
    a_ax <= first_point_x;
    a_ay <= first_point_y;
    a_ux <= first_dir_x;
    a_uy <= first_dir_y;
    a_vx <= second_dir_x;
    a_vy <= second_dir_y;
    a_ex <= {second_point_x[31], second_point_x} - {first_point_x[31], first_point_x};
    a_ey <= {second_point_y[31], second_point_y} - {first_point_y[31], first_point_y};
    // B
    b_ax  <= a_ax;
    b_ay  <= a_ay;
    b_ux  <= a_ux;
    b_uy  <= a_uy;
    b_pd1 <= a_ux * a_vy;
    b_pd2 <= a_uy * a_vx;
    b_pn1 <= a_ex * a_vy;
    b_pn2 <= a_ey * a_vx;
    // C
    c_ax <= b_ax;
    c_ay <= b_ay;
    c_ux <= b_ux;
    c_uy <= b_uy;
    c_d  <= {b_pd1[63], b_pd1} - {b_pd2[63], b_pd2};
    c_n  <= {b_pn1[64], b_pn1} - {b_pn2[64], b_pn2};
    // D
    d_ax   <= c_ax;
    d_ay   <= c_ay;
    d_dmag <= dmag_c;
    d_nmag <= nmag_c;
    d_mux  <= c_ux[31] ? 32'(-c_ux) : 32'(c_ux);
    d_muy  <= c_uy[31] ? 32'(-c_uy) : 32'(c_uy);
    d_negx <= c_ux[31] ^ c_n[65] ^ c_d[64];
    d_negy <= c_uy[31] ^ c_n[65] ^ c_d[64];
    if (par_d) begin
      d_kind <= par_n ? lix_pkg::HIT_COINCIDENT : lix_pkg::HIT_NONE;
    end else begin
      d_kind <= lix_pkg::HIT_POINT;
    end
    // E
    e_kind <= d_kind;
    e_ax   <= d_ax;
    e_ay   <= d_ay;
    e_den  <= d_dmag;
    e_negx <= d_negx;
    e_negy <= d_negy;
    e_plx  <= d_nmag[31:0] * d_mux;
    e_ply  <= d_nmag[31:0] * d_muy;
    e_phx  <= d_nmag[64:32] * d_mux;
    e_phy  <= d_nmag[64:32] * d_muy;
    // F
    f_kind <= e_kind;
    f_ax   <= e_ax;
    f_ay   <= e_ay;
    f_den  <= e_den;
    f_negx <= e_negx;
    f_negy <= e_negy;
    f_numx <= {32'd0, e_plx} + {e_phx[63:0], 32'd0};
    f_numy <= {32'd0, e_ply} + {e_phy[63:0], 32'd0};
    // G: quotient range check, seed the cell row
    if (rst) begin
      div_out.valid <= 1'b0;
    end else begin
      div_out.valid <= f_valid;
    end
    div_out.kind   <= f_kind;
    div_out.den    <= f_den;
    div_out.rem_x  <= f_numx;
    div_out.rem_y  <= f_numy;
    div_out.quo_x  <= '0;
    div_out.quo_y  <= '0;
    div_out.neg_x  <= f_negx;
    div_out.neg_y  <= f_negy;
    div_out.big_x  <= {30'd0, f_numx[95:62]} >= f_den;
    div_out.big_y  <= {30'd0, f_numy[95:62]} >= f_den;
    div_out.base_x <= f_ax;
    div_out.base_y <= f_ay;
  end

endmodule

// File: sv/lix_cell.sv
// One restoring-division cell: resolves quotient bit BIT for both lanes.
// Depends on lix_pkg; instantiated in a row by the top level.
module lix_cell #(
  parameter int BIT = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  lix_pkg::lix_div_t cell_in,
  output lix_pkg::lix_div_t cell_out
);

  logic [lix_pkg::NUM_WIDTH-1:0] den_w, den_sh;
  logic                          ge_x, ge_y;

  always_comb begin
    den_w  = {{(lix_pkg::NUM_WIDTH-lix_pkg::DEN_WIDTH){1'b0}}, cell_in.den};
    den_sh = den_w << BIT;
    ge_x   = (cell_in.rem_x >> BIT) >= den_w;
    ge_y   = (cell_in.rem_y >> BIT) >= den_w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_out.valid <= 1'b0;
    end else begin
      cell_out.valid <= cell_in.valid;
    end
    cell_out.kind   <= cell_in.kind;
    cell_out.den    <= cell_in.den;
    cell_out.neg_x  <= cell_in.neg_x;
    cell_out.neg_y  <= cell_in.neg_y;
    cell_out.big_x  <= cell_in.big_x;
    cell_out.big_y  <= cell_in.big_y;
    cell_out.base_x <= cell_in.base_x;
    cell_out.base_y <= cell_in.base_y;
    cell_out.rem_x  <= ge_x ? cell_in.rem_x - den_sh : cell_in.rem_x;
    cell_out.rem_y  <= ge_y ? cell_in.rem_y - den_sh : cell_in.rem_y;
    cell_out.quo_x  <= cell_in.quo_x | ({{(lix_pkg::QUO_BITS-1){1'b0}}, ge_x} << BIT);
    cell_out.quo_y  <= cell_in.quo_y | ({{(lix_pkg::QUO_BITS-1){1'b0}}, ge_y} << BIT);
  end

endmodule

// File: sv/lix_back.sv
// Output stage: signs the quotient, adds the base point and saturates.
// Depends on lix_pkg; takes the last cell of the divider row.
module lix_back #(
  parameter int COORD_WIDTH = lix_pkg::COORD_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  lix_pkg::lix_div_t  div_in,
  output logic               done,
  output logic [1:0]         hit_kind,
  output logic signed [31:0] cross_x,
  output logic signed [31:0] cross_y,
  output logic               overflow
);

  localparam logic signed [63:0] SAT_HI = 64'sd2 ** (COORD_WIDTH - 1) - 64'sd1;
  localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

  logic signed [63:0] qx, qy, sx, sy, rx, ry;
  logic               ox, oy;

  always_comb begin
    qx = $signed({2'b00, div_in.quo_x});
    qy = $signed({2'b00, div_in.quo_y});
    sx = 64'(div_in.base_x) + (div_in.neg_x ? -qx : qx);
    sy = 64'(div_in.base_y) + (div_in.neg_y ? -qy : qy);
    ox = 1'b1;
    oy = 1'b1;
    if (div_in.big_x) begin
      rx = div_in.neg_x ? SAT_LO : SAT_HI;
    end else if (sx > SAT_HI) begin
      rx = SAT_HI;
    end else if (sx < SAT_LO) begin
      rx = SAT_LO;
    end else begin
      rx = sx;
      ox = 1'b0;
    end
    if (div_in.big_y) begin
      ry = div_in.neg_y ? SAT_LO : SAT_HI;
    end else if (sy > SAT_HI) begin
      ry = SAT_HI;
    end else if (sy < SAT_LO) begin
      ry = SAT_LO;
    end else begin
      ry = sy;
      oy = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= div_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    hit_kind <= div_in.kind;
    if (div_in.kind == lix_pkg::HIT_POINT) begin
      cross_x  <= rx[31:0];
      cross_y  <= ry[31:0];
      overflow <= ox | oy;
    end else begin
      cross_x  <= '0;
      cross_y  <= '0;
      overflow <= 1'b0;
    end
  end

endmodule

// File: sv/lix_checker.sv
// Port-level checker for line_intersection_2d, attached by bind.
// Depends on lix_pkg.
module lix_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic [1:0]         hit_kind,
  input logic signed [31:0] cross_x,
  input logic signed [31:0] cross_y,
  input logic               overflow
);

  a_rst_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  a_rst_busy: assert property (@(posedge clk) rst |=> busy)
    else $error("busy not raised after reset");

  a_fixed_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, lix_pkg::LATENCY))
    else $error("result without a transfer at the fixed latency");

  a_no_point_zero: assert property (@(posedge clk) disable iff (rst)
    (done && hit_kind != lix_pkg::HIT_POINT) |->
      (cross_x == 32'sd0 && cross_y == 32'sd0 && !overflow))
    else $error("nonzero coordinates on a non-point result");

endmodule

bind line_intersection_2d lix_checker u_lix_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .done     (done),
  .hit_kind (hit_kind),
  .cross_x  (cross_x),
  .cross_y  (cross_y),
  .overflow (overflow)
);
